### sv/i2c_register_byte_master_core_macros.svh
// assertion macros used by the checker file
`ifndef I2C_REGISTER_BYTE_MASTER_CORE_MACROS_SVH
`define I2C_REGISTER_BYTE_MASTER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c master check failed");

// next-cycle implication
`define RBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c master check failed");

`endif

### sv/i2crbm_pkg.sv
// types, codes and line tables of the register byte i2c master
package i2crbm_pkg;

  typedef enum logic [3:0] {
    OP_START, OP_ADDR_W, OP_ADDR_R, OP_REG, OP_DATA, OP_ACK, OP_RBYTE, OP_MNACK, OP_STOP
  } op_t;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [3:0] WRITE_LEN = 4'd8;
  localparam logic [3:0] READ_LEN  = 4'd12;

  localparam logic [6:0]  DEV_ADDR_RST = 7'd82;
  localparam logic [15:0] HOLD_RST     = 16'd80;

  localparam int CFG_AW = 3;
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  typedef struct packed {
    logic [3:0]  phase;
    logic [1:0]  seg;
    logic [2:0]  bit_idx;
    logic [7:0]  shift;
    logic [15:0] hold;
    logic        is_read;
    logic [7:0]  saved_reg;
    logic [7:0]  saved_data;
    logic [7:0]  read_byte;
    logic        nack;
    logic        scl;
    logic        sda;
  } seq_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       nack_seen;
  } res_t;

  // script position to operation; unlisted positions read as start
  function automatic op_t op_at(input logic is_read, input logic [3:0] pos);
    op_t op;
    op = OP_START;
    if (is_read) begin
      case (pos)
        4'd1, 4'd7: op = OP_ADDR_W;
        4'd2, 4'd4, 4'd8: op = OP_ACK;
        4'd3: op = OP_REG;
        4'd5, 4'd11, 4'd12: op = OP_STOP;
        default: op = OP_START;
      endcase
      if (pos == 4'd7) op = OP_ADDR_R;
      if (pos == 4'd9) op = OP_RBYTE;
      if (pos == 4'd10) op = OP_MNACK;
    end else begin
      case (pos)
        4'd1: op = OP_ADDR_W;
        4'd2, 4'd4, 4'd6: op = OP_ACK;
        4'd3: op = OP_REG;
        4'd5: op = OP_DATA;
        4'd7: op = OP_STOP;
        default: op = OP_START;
      endcase
    end
    return op;
  endfunction

  function automatic logic [2:0] seg_count(input op_t op);
    logic [2:0] n;
    case (op)
      OP_START: n = 3'd2;
      OP_ACK:   n = 3'd4;
      default:  n = 3'd3;
    endcase
    return n;
  endfunction

  function automatic logic is_wbyte(input op_t op);
    return (op == OP_ADDR_W) || (op == OP_ADDR_R) || (op == OP_REG) || (op == OP_DATA);
  endfunction

  // {scl, sda} for a segment of an operation
  function automatic logic [1:0] lines_for(input op_t op, input logic [1:0] seg,
                                           input logic msb);
    logic scl;
    logic sda;
    case (op)
      OP_START: begin
        scl = 1'b1;
        sda = (seg == 2'd0);
      end
      OP_ACK: begin
        scl = (seg == 2'd1) || (seg == 2'd2);
        sda = 1'b1;
      end
      OP_RBYTE: begin
        scl = (seg != 2'd2);
        sda = 1'b1;
      end
      OP_MNACK: begin
        scl = (seg == 2'd1);
        sda = 1'b1;
      end
      OP_STOP: begin
        scl = (seg != 2'd0);
        sda = (seg == 2'd2);
      end
      default: begin
        scl = (seg == 2'd1);
        sda = msb;
      end
    endcase
    return {scl, sda};
  endfunction

endpackage

### sv/i2crbm_if.sv
// handshake channels for request words and result words
interface i2crbm_in_if;
  import i2crbm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] reg_addr;
  logic [7:0] wr_data;
  logic       sda_in;
  modport source (output valid, kind, reg_addr, wr_data, sda_in, input ready);
  modport sink (input valid, kind, reg_addr, wr_data, sda_in, output ready);
endinterface

interface i2crbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rd_data;
  logic       nack_seen;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, rd_data, nack_seen,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rd_data, nack_seen,
                output ready);
endinterface

### sv/i2crbm_cfg.sv
// apb-style register bank: device address and hold ticks
module i2crbm_cfg import i2crbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [6:0]        dev_addr,
  output logic [15:0]       hold_ticks
);

  logic [6:0]  dev_addr_r;
  logic [15:0] hold_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // byte lanes are ignored, the word index is paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      hold_r     <= HOLD_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_DEV_ADDR) dev_addr_r <= pwdata[6:0];
      else hold_r <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_HOLD) prdata = {16'd0, hold_r};
    else prdata = {25'd0, dev_addr_r};
  end

  assign dev_addr   = dev_addr_r;
  assign hold_ticks = hold_r;

endmodule

### sv/i2crbm_seq.sv
// transfer sequencer: state register and single-pass next-state logic
module i2crbm_seq import i2crbm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wr_data,
  input  logic        sda_in,
  input  logic [6:0]  dev_addr,
  input  logic [15:0] hold_ticks,
  output res_t        res
);

  seq_state_t st_r;
  seq_state_t st_nxt;
  logic       done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{scl: 1'b1, sda: 1'b1, default: '0};
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    op_t         cur_op;
    op_t         new_op;
    logic [15:0] limit;
    logic [16:0] cnt_inc;
    logic [2:0]  seg_n;
    logic [3:0]  len;
    st_nxt  = st_r;
    done    = 1'b0;
    limit   = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
    cnt_inc = {1'b0, st_r.hold} + 17'd1;
    cur_op  = op_at(st_r.is_read, st_r.phase - 4'd1);
    new_op  = op_at(st_r.is_read, st_r.phase);
    seg_n   = {1'b0, st_r.seg} + 3'd1;
    len     = st_r.is_read ? READ_LEN : WRITE_LEN;
    if (st_r.phase == 4'd0) begin
      if (kind == KIND_WRITE || kind == KIND_READ) begin
        st_nxt.is_read    = (kind == KIND_READ);
        st_nxt.saved_reg  = reg_addr;
        st_nxt.saved_data = wr_data;
        st_nxt.nack       = 1'b0;
        st_nxt.hold       = '0;
        st_nxt.phase      = 4'd1;
        st_nxt.seg        = '0;
        st_nxt.bit_idx    = '0;
        {st_nxt.scl, st_nxt.sda} = lines_for(OP_START, 2'd0, 1'b0);
      end
    end else if (kind == KIND_TICK) begin
      if (cnt_inc < {1'b0, limit}) begin
        st_nxt.hold = cnt_inc[15:0];
      end else begin
        st_nxt.hold = '0;
        // ack slot sampled at the end of its first high segment
        if (cur_op == OP_ACK && st_r.seg == 2'd1 && sda_in) st_nxt.nack = 1'b1;
        if (cur_op == OP_RBYTE && st_r.seg == 2'd1) st_nxt.shift = {st_r.shift[6:0], sda_in};
        if (seg_n >= seg_count(cur_op)) begin
          if ((is_wbyte(cur_op) || cur_op == OP_RBYTE) && st_r.bit_idx != 3'd7) begin
            st_nxt.bit_idx = st_r.bit_idx + 3'd1;
            st_nxt.seg     = '0;
            if (is_wbyte(cur_op)) st_nxt.shift = {st_r.shift[6:0], 1'b0};
            {st_nxt.scl, st_nxt.sda} = lines_for(cur_op, 2'd0, st_nxt.shift[7]);
          end else if (st_r.phase >= len) begin
            done = 1'b1;
            if (st_r.is_read) st_nxt.read_byte = st_nxt.shift;
            st_nxt.phase   = '0;
            st_nxt.seg     = '0;
            st_nxt.bit_idx = '0;
            st_nxt.scl     = 1'b1;
            st_nxt.sda     = 1'b1;
          end else begin
            st_nxt.phase   = st_r.phase + 4'd1;
            st_nxt.seg     = '0;
            st_nxt.bit_idx = '0;
            case (new_op)
              OP_ADDR_W: st_nxt.shift = {dev_addr, 1'b0};
              OP_ADDR_R: st_nxt.shift = {dev_addr, 1'b1};
              OP_REG:    st_nxt.shift = st_r.saved_reg;
              OP_DATA:   st_nxt.shift = st_r.saved_data;
              OP_RBYTE:  st_nxt.shift = '0;
              default:   st_nxt.shift = st_nxt.shift;
            endcase
            {st_nxt.scl, st_nxt.sda} = lines_for(new_op, 2'd0, st_nxt.shift[7]);
          end
        end else begin
          st_nxt.seg = seg_n[1:0];
          {st_nxt.scl, st_nxt.sda} = lines_for(cur_op, seg_n[1:0], st_nxt.shift[7]);
        end
      end
    end
  end

  always_comb begin
    res.scl_out   = st_nxt.scl;
    res.sda_out   = st_nxt.sda;
    res.busy_res  = (st_nxt.phase != 4'd0);
    res.done_res  = done;
    res.rd_data   = st_nxt.read_byte;
    res.nack_seen = st_nxt.nack;
  end

endmodule

### sv/i2crbm_oreg.sv
// result register: holds one word until the sink takes it
module i2crbm_oreg import i2crbm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  input  logic out_ready,
  output logic out_valid,
  output logic in_ready,
  output res_t out_word
);

  logic valid_r;
  res_t word_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) word_r <= res;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

### sv/i2c_register_byte_master_core.sv
// latency: a result word is valid the cycle after its request or tick word is accepted
// throughput: one word per cycle while the sink keeps up; the state update and result register load together
// a stalled result register holds off input only until the sink takes the word
// reset: synchronous active-low rst_n; bus lines released, sequencer idle,
// device address 82 and hold ticks 80, no result pending
module i2c_register_byte_master_core import i2crbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  i2crbm_in_if.sink         in_ch,
  i2crbm_out_if.source      out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [6:0]  dev_addr;
  logic [15:0] hold_ticks;
  logic        in_ready;
  logic        accept;
  res_t        res;
  res_t        out_word;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  i2crbm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .dev_addr   (dev_addr),
    .hold_ticks (hold_ticks)
  );

  i2crbm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_ch.kind),
    .reg_addr   (in_ch.reg_addr),
    .wr_data    (in_ch.wr_data),
    .sda_in     (in_ch.sda_in),
    .dev_addr   (dev_addr),
    .hold_ticks (hold_ticks),
    .res        (res)
  );

  i2crbm_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .in_ready  (in_ready),
    .out_word  (out_word)
  );

  assign out_ch.scl_out   = out_word.scl_out;
  assign out_ch.sda_out   = out_word.sda_out;
  assign out_ch.busy_res  = out_word.busy_res;
  assign out_ch.done_res  = out_word.done_res;
  assign out_ch.rd_data   = out_word.rd_data;
  assign out_ch.nack_seen = out_word.nack_seen;

endmodule

### sv/i2crbm_checker.sv
// port-level checks on the i2c master, bound to the top level
`include "i2c_register_byte_master_core_macros.svh"

module i2crbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_out,
  input logic       sda_out,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rd_data,
  input logic       nack_seen
);

  // a stalled result word stays put
  `RBM_ASSERT_NXT(a_hold_word, out_valid && !out_ready,
                  out_valid && $stable({scl_out, sda_out, busy_res, done_res, rd_data, nack_seen}))

  // every accepted word yields a result in the next cycle
  `RBM_ASSERT_NXT(a_word_result, in_valid && in_ready, out_valid)

  // a finished transfer leaves the bus idle and released
  `RBM_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res && scl_out && sda_out)

  // both lines released whenever no transfer runs
  `RBM_ASSERT_IMP(a_idle_released, out_valid && !busy_res, scl_out && sda_out)

endmodule

bind i2c_register_byte_master_core i2crbm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl_out   (out_ch.scl_out),
  .sda_out   (out_ch.sda_out),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .rd_data   (out_ch.rd_data),
  .nack_seen (out_ch.nack_seen)
);
